// ===== rtl/core/ttd_pkg.sv =====
// ttd_pkg: shared types and register indexes for the touch tap/drag classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package ttd_pkg;

  localparam int unsigned RAW_W   = 12;  // raw signed touch coordinate
  localparam int unsigned OUT_C_W = 11;  // start point field
  localparam int unsigned OUT_D_W = 12;  // offset field
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LIMIT     = 3'd0,
    REG_Y_LIMIT     = 3'd1,
    REG_GESTURE_TMO = 3'd2,
    REG_DRAG_THRESH = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_TAP  = 2'd1,
    EV_DRAG = 2'd2
  } event_kind_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_ACK    = 1'b1
  } req_type_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [RAW_W-1:0]  sample_x;
    logic signed [RAW_W-1:0]  sample_y;
    logic [TIME_W-1:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    event_kind_t               event_kind;
    logic                      sample_accepted;
    logic [OUT_C_W-1:0]        start_x;
    logic [OUT_C_W-1:0]        start_y;
    logic signed [OUT_D_W-1:0] drag_dx;
    logic signed [OUT_D_W-1:0] drag_dy;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [11:0] x_limit;
    logic [11:0] y_limit;
    logic [15:0] gesture_timeout_ms;
    logic [11:0] drag_threshold;
  } cfg_t;

  // Flags of one snapshot handed from the state stage to the classify stage.
  typedef struct packed {
    logic valid;
    logic accepted;
    logic pending;
  } snap_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ttd_chan_if.sv =====
// ttd_chan_if: valid/ready channel carrying one payload item.
// Payload type is a parameter; used with the structs of ttd_pkg.
`default_nettype none

interface ttd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/touch_tap_drag_classifier_unit.sv =====
// touch_tap_drag_classifier_unit: top level of the touch tap/drag classifier.
// Depends on ttd_pkg, ttd_chan_if, ttd_cfg_regs, ttd_state, ttd_classify.
//
//  channel  | direction | payload     | handshake
//  ---------+-----------+-------------+-------------------------------
//  in_ch    | sink      | in_item_t   | valid & ready, one item per edge
//  out_ch   | source    | out_item_t  | valid & ready, one item per edge
//  cfg_ch   | sink      | cfg_item_t  | valid & ready, ready always high
//
// Two register stages: gesture state plus snapshot, then classify into the
// result register. One item is accepted every cycle while out_ch does not stall.
// The squared-distance multipliers in ttd_classify set the critical path.
// A stalled result holds the result register; the snapshot stage keeps
// taking one more item, then in_ch.ready drops until out_ch takes the result.
// rst_n is synchronous: config returns to its defaults, gesture state clears.
`default_nettype none

module touch_tap_drag_classifier_unit
  import ttd_pkg::*;
#(
  parameter int unsigned COORD_BITS = 11
)(
  input  wire logic clk,
  input  wire logic rst_n,
  ttd_chan_if.sink   in_ch,
  ttd_chan_if.source out_ch,
  ttd_chan_if.sink   cfg_ch
);

  cfg_t                  cfg;
  snap_ctl_t             snap_ctl;
  logic                  snap_take;
  logic [COORD_BITS-1:0] snap_sx, snap_sy, snap_ex, snap_ey;
  logic                  in_rdy;
  logic                  out_vld;
  out_item_t             out_item;

  assign cfg_ch.ready = 1'b1;

  ttd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_item (cfg_ch.data),
    .cfg     (cfg)
  );

  ttd_state #(.COORD_BITS(COORD_BITS)) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_item   (in_ch.data),
    .in_ready  (in_rdy),
    .snap_take (snap_take),
    .snap_ctl  (snap_ctl),
    .snap_sx   (snap_sx),
    .snap_sy   (snap_sy),
    .snap_ex   (snap_ex),
    .snap_ey   (snap_ey)
  );

  ttd_classify #(.COORD_BITS(COORD_BITS)) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .snap_ctl  (snap_ctl),
    .snap_sx   (snap_sx),
    .snap_sy   (snap_sy),
    .snap_ex   (snap_ex),
    .snap_ey   (snap_ey),
    .snap_take (snap_take),
    .out_valid (out_vld),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_item;

endmodule

`default_nettype wire

// ===== rtl/core/ttd_cfg_regs.sv =====
// ttd_cfg_regs: configuration register file of the classifier.
// Depends on ttd_pkg; written through the cfg channel, always ready.
`default_nettype none

module ttd_cfg_regs
  import ttd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  cfg_item_t wr_item,
  output cfg_t      cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_item.index)
        REG_X_LIMIT:     cfg_nxt.x_limit            = wr_item.data[11:0];
        REG_Y_LIMIT:     cfg_nxt.y_limit            = wr_item.data[11:0];
        REG_GESTURE_TMO: cfg_nxt.gesture_timeout_ms = wr_item.data;
        REG_DRAG_THRESH: cfg_nxt.drag_threshold     = wr_item.data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_limit            <= 12'd320;
      cfg_r.y_limit            <= 12'd240;
      cfg_r.gesture_timeout_ms <= 16'd50;
      cfg_r.drag_threshold     <= 12'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/ttd_state.sv =====
// ttd_state: gesture state update and snapshot register (first stage).
// Depends on ttd_pkg. Feeds ttd_classify with the post-update gesture points.
`default_nettype none

module ttd_state
  import ttd_pkg::*;
#(
  parameter int unsigned COORD_BITS = 11
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cfg_t                       cfg,
  input  wire logic                  in_valid,
  input  in_item_t                   in_item,
  output logic                       in_ready,
  input  wire logic                  snap_take,
  output snap_ctl_t                  snap_ctl,
  output logic [COORD_BITS-1:0]      snap_sx,
  output logic [COORD_BITS-1:0]      snap_sy,
  output logic [COORD_BITS-1:0]      snap_ex,
  output logic [COORD_BITS-1:0]      snap_ey
);

  // architectural gesture state
  logic [COORD_BITS-1:0] start_x_r, start_x_nxt;
  logic [COORD_BITS-1:0] start_y_r, start_y_nxt;
  logic [COORD_BITS-1:0] end_x_r, end_x_nxt;
  logic [COORD_BITS-1:0] end_y_r, end_y_nxt;
  logic [TIME_W-1:0]     last_time_r, last_time_nxt;
  logic                  pending_r, pending_nxt;

  // snapshot stage
  logic                  sv_r, sv_nxt;
  logic                  s_acc_r, s_pend_r;
  logic [COORD_BITS-1:0] s_sx_r, s_sy_r, s_ex_r, s_ey_r;

  logic                  in_fire;
  logic                  is_ack;
  logic                  in_bounds;
  logic [COORD_BITS-1:0] ux, uy;
  logic [TIME_W-1:0]     gap;
  logic                  new_gesture;

  assign in_ready = !sv_r || snap_take;
  assign in_fire  = in_valid && in_ready;
  assign is_ack   = (in_item.req_type == REQ_ACK);

  // sign bit clear means a reading; compare the magnitude against the bounds
  assign in_bounds = !in_item.sample_x[RAW_W-1] && !in_item.sample_y[RAW_W-1] &&
                     ({1'b0, in_item.sample_x[RAW_W-2:0]} < cfg.x_limit) &&
                     ({1'b0, in_item.sample_y[RAW_W-2:0]} < cfg.y_limit);

  assign ux = COORD_BITS'(in_item.sample_x[RAW_W-2:0]);
  assign uy = COORD_BITS'(in_item.sample_y[RAW_W-2:0]);

  assign gap         = in_item.time_ms - last_time_r;   // wraps mod 2^32
  assign new_gesture = gap >= TIME_W'(cfg.gesture_timeout_ms);

  always_comb begin
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    end_x_nxt     = end_x_r;
    end_y_nxt     = end_y_r;
    last_time_nxt = last_time_r;
    pending_nxt   = pending_r;
    if (in_fire && !is_ack && in_bounds) begin
      pending_nxt   = 1'b1;
      end_x_nxt     = ux;
      end_y_nxt     = uy;
      last_time_nxt = in_item.time_ms;
      if (new_gesture) begin
        start_x_nxt = ux;
        start_y_nxt = uy;
      end
    end
  end

  always_comb begin
    sv_nxt = sv_r;
    if (in_fire) begin
      sv_nxt = 1'b1;
    end else if (snap_take) begin
      sv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      start_y_r   <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      last_time_r <= '0;
      pending_r   <= 1'b0;
      sv_r        <= 1'b0;
    end else begin
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      end_x_r     <= end_x_nxt;
      end_y_r     <= end_y_nxt;
      last_time_r <= last_time_nxt;
      // an ack reports the event first, then clears it
      pending_r   <= (in_fire && is_ack) ? 1'b0 : pending_nxt;
      sv_r        <= sv_nxt;
    end
  end

  // snapshot payload: post-update state for a sample, current state for an ack
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_acc_r  <= !is_ack && in_bounds;
      s_pend_r <= pending_nxt;
      s_sx_r   <= start_x_nxt;
      s_sy_r   <= start_y_nxt;
      s_ex_r   <= end_x_nxt;
      s_ey_r   <= end_y_nxt;
    end
  end

  assign snap_ctl.valid    = sv_r;
  assign snap_ctl.accepted = s_acc_r;
  assign snap_ctl.pending  = s_pend_r;
  assign snap_sx = s_sx_r;
  assign snap_sy = s_sy_r;
  assign snap_ex = s_ex_r;
  assign snap_ey = s_ey_r;

endmodule

`default_nettype wire

// ===== rtl/core/ttd_classify.sv =====
// ttd_classify: offset, squared distance and tap/drag decision (second stage).
// Depends on ttd_pkg; drives the result register of the block.
`default_nettype none

module ttd_classify
  import ttd_pkg::*;
#(
  parameter int unsigned COORD_BITS = 11
)(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  cfg_t                  cfg,
  input  snap_ctl_t             snap_ctl,
  input  wire logic [COORD_BITS-1:0] snap_sx,
  input  wire logic [COORD_BITS-1:0] snap_sy,
  input  wire logic [COORD_BITS-1:0] snap_ex,
  input  wire logic [COORD_BITS-1:0] snap_ey,
  output logic                  snap_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  localparam int unsigned DXW = COORD_BITS + 1;
  localparam int unsigned SQW = 2 * DXW;
  localparam int unsigned CMPW = (SQW + 1 > 24) ? SQW + 1 : 24;

  logic signed [DXW-1:0] dx, dy;
  logic signed [31:0]    dx_ext, dy_ext;
  logic [SQW-1:0]        dx2, dy2;
  logic [SQW:0]          d2;
  logic [23:0]           t2;
  event_kind_t           kind;

  logic      ov_r, ov_nxt;
  out_item_t res_r, res_nxt;

  assign dx = signed'({1'b0, snap_ex}) - signed'({1'b0, snap_sx});
  assign dy = signed'({1'b0, snap_ey}) - signed'({1'b0, snap_sy});
  assign dx_ext = 32'(dx);
  assign dy_ext = 32'(dy);

  // widen before squaring so the full product is kept
  assign dx2 = unsigned'(SQW'(dx) * SQW'(dx));
  assign dy2 = unsigned'(SQW'(dy) * SQW'(dy));
  assign d2  = {1'b0, dx2} + {1'b0, dy2};
  assign t2  = 24'(cfg.drag_threshold) * 24'(cfg.drag_threshold);

  always_comb begin
    if (!snap_ctl.pending) begin
      kind = EV_NONE;
    end else if (CMPW'(d2) >= CMPW'(t2)) begin
      kind = EV_DRAG;
    end else begin
      kind = EV_TAP;
    end
  end

  assign snap_take = !ov_r || out_ready;

  always_comb begin
    res_nxt.event_kind      = kind;
    res_nxt.sample_accepted = snap_ctl.accepted;
    res_nxt.start_x         = OUT_C_W'(32'(snap_sx));
    res_nxt.start_y         = OUT_C_W'(32'(snap_sy));
    res_nxt.drag_dx         = dx_ext[OUT_D_W-1:0];
    res_nxt.drag_dy         = dy_ext[OUT_D_W-1:0];
    ov_nxt = ov_r;
    if (snap_take) begin
      ov_nxt = snap_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_ctl.valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = res_r;

endmodule

`default_nettype wire

// ===== tb/ttd_result_checker.sv =====
// ttd_result_checker: watches the input, result and register channels of the
// touch tap/drag classifier, predicts each result and compares it.
// Depends on ttd_pkg only.

module ttd_result_checker
  import ttd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  cfg_item_t         cfg_data,
  output int unsigned       fail_count,
  output int unsigned       results_due
);

  localparam int unsigned MAX_REPORTS = 30;

  cfg_t               regs;
  logic [OUT_C_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [TIME_W-1:0]  last_stamp;
  bit                 touch_pending;
  out_item_t          gesture_q[$];

  // Result fields as seen from the current gesture state.
  function automatic out_item_t gesture_report(input bit accepted);
    out_item_t r;
    int dx, dy;
    longint unsigned dist2, thr2;
    dx    = int'(end_x_q) - int'(start_x_q);
    dy    = int'(end_y_q) - int'(start_y_q);
    dist2 = longint'(dx * dx) + longint'(dy * dy);
    thr2  = longint'(regs.drag_threshold) * longint'(regs.drag_threshold);
    if (!touch_pending)
      r.event_kind = EV_NONE;
    else if (dist2 >= thr2)
      r.event_kind = EV_DRAG;
    else
      r.event_kind = EV_TAP;
    r.sample_accepted = accepted;
    r.start_x = start_x_q;
    r.start_y = start_y_q;
    r.drag_dx = dx[OUT_D_W-1:0];
    r.drag_dy = dy[OUT_D_W-1:0];
    return r;
  endfunction

  task automatic track_gesture(input in_item_t it, output out_item_t r);
    bit in_bounds;
    logic [TIME_W-1:0] gap;
    if (it.req_type == REQ_ACK) begin
      // report first, then clear
      r = gesture_report(1'b0);
      touch_pending = 1'b0;
    end else begin
      in_bounds = !it.sample_x[RAW_W-1] && !it.sample_y[RAW_W-1] &&
                  ({1'b0, it.sample_x[RAW_W-2:0]} < regs.x_limit) &&
                  ({1'b0, it.sample_y[RAW_W-2:0]} < regs.y_limit);
      if (in_bounds) begin
        touch_pending = 1'b1;
        end_x_q = it.sample_x[OUT_C_W-1:0];
        end_y_q = it.sample_y[OUT_C_W-1:0];
        gap = it.time_ms - last_stamp;
        if (gap >= {16'd0, regs.gesture_timeout_ms}) begin
          start_x_q = it.sample_x[OUT_C_W-1:0];
          start_y_q = it.sample_y[OUT_C_W-1:0];
        end
        last_stamp = it.time_ms;
      end
      r = gesture_report(in_bounds);
    end
  endtask

  task automatic compare_result(input out_item_t want, input out_item_t got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        if (want.event_kind !== got.event_kind)
          $display("%0t: event_kind expected %0d actual %0d", $time,
                   want.event_kind, got.event_kind);
        if (want.sample_accepted !== got.sample_accepted)
          $display("%0t: sample_accepted expected %0d actual %0d", $time,
                   want.sample_accepted, got.sample_accepted);
        if (want.start_x !== got.start_x)
          $display("%0t: start_x expected %0d actual %0d", $time,
                   want.start_x, got.start_x);
        if (want.start_y !== got.start_y)
          $display("%0t: start_y expected %0d actual %0d", $time,
                   want.start_y, got.start_y);
        if (want.drag_dx !== got.drag_dx)
          $display("%0t: drag_dx expected %0d actual %0d", $time,
                   want.drag_dx, got.drag_dx);
        if (want.drag_dy !== got.drag_dy)
          $display("%0t: drag_dy expected %0d actual %0d", $time,
                   want.drag_dy, got.drag_dy);
      end else if (fail_count == MAX_REPORTS + 1) begin
        $display("%0t: further mismatches counted but not listed", $time);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs.x_limit            = 12'd320;
      regs.y_limit            = 12'd240;
      regs.gesture_timeout_ms = 16'd50;
      regs.drag_threshold     = 12'd10;
      start_x_q     = '0;
      start_y_q     = '0;
      end_x_q       = '0;
      end_y_q       = '0;
      last_stamp    = '0;
      touch_pending = 1'b0;
      gesture_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_X_LIMIT:     regs.x_limit            = cfg_data.data[11:0];
          REG_Y_LIMIT:     regs.y_limit            = cfg_data.data[11:0];
          REG_GESTURE_TMO: regs.gesture_timeout_ms = cfg_data.data;
          REG_DRAG_THRESH: regs.drag_threshold     = cfg_data.data[11:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (gesture_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, actual %h", $time, out_data);
        end else begin
          compare_result(gesture_q.pop_front(), out_data);
        end
      end
      if (in_valid && in_ready) begin
        track_gesture(in_data, want);
        gesture_q.push_back(want);
      end
    end
    results_due = gesture_q.size();
  end

endmodule

// ===== tb/touch_tap_drag_classifier_unit_tb.sv =====
// touch_tap_drag_classifier_unit_tb: stimulus and verdict for the classifier.
// Depends on ttd_pkg, ttd_chan_if, the block and ttd_result_checker.

module touch_tap_drag_classifier_unit_tb;
  import ttd_pkg::*;

  localparam int unsigned PHASE_ITEMS    = 275;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 4;

  logic clk;
  logic rst_n;

  ttd_chan_if #(.T(in_item_t))  in_ch();
  ttd_chan_if #(.T(out_item_t)) out_ch();
  ttd_chan_if #(.T(cfg_item_t)) cfg_ch();

  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;
  bit           hold_req;
  int unsigned  fail_count;
  int unsigned  results_due;
  int unsigned  items_sent;
  int unsigned  acks_sent;
  int unsigned  settings_used;
  cfg_t         cur_cfg;
  logic [31:0]  now_ms;

  touch_tap_drag_classifier_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ttd_result_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, quiet);
    $display("touch_tap_drag_classifier_unit_tb: FAIL");
    $finish;
  end

  function automatic int clamp_coord(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  task automatic send_item(input in_item_t it);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (it.req_type == REQ_ACK)
      acks_sent++;
  endtask

  task automatic send_touch(input int x, input int y, input logic [31:0] t);
    in_item_t it;
    it.req_type = REQ_SAMPLE;
    it.sample_x = x[11:0];
    it.sample_y = y[11:0];
    it.time_ms  = t;
    send_item(it);
  endtask

  // Coordinates and time of an acknowledge are don't-care; fill with noise.
  task automatic send_ack();
    in_item_t it;
    it.req_type = REQ_ACK;
    it.sample_x = $urandom;
    it.sample_y = $urandom;
    it.time_ms  = $urandom;
    send_item(it);
  endtask

  // Stop offering items until every result is back, then let the pipe empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_item_t c;
    c.index = idx;
    c.data  = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h,
                            input int unsigned tmo, input int unsigned thr);
    settle();
    cur_cfg.x_limit            = w[11:0];
    cur_cfg.y_limit            = h[11:0];
    cur_cfg.gesture_timeout_ms = tmo[15:0];
    cur_cfg.drag_threshold     = thr[11:0];
    write_reg(REG_X_LIMIT,     16'(w));
    write_reg(REG_Y_LIMIT,     16'(h));
    write_reg(REG_GESTURE_TMO, 16'(tmo));
    write_reg(REG_DRAG_THRESH, 16'(thr));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly whole gestures (fresh start, a few moves near the drag distance,
  // acknowledge), mixed with stray acknowledges and junk samples.
  task automatic run_phase(input int unsigned n_items);
    int unsigned done_n, len, tmo, step;
    int w, h, sx, sy, ex, ey, reach;
    done_n = 0;
    while (done_n < n_items) begin
      w     = int'(cur_cfg.x_limit);
      h     = int'(cur_cfg.y_limit);
      tmo   = cur_cfg.gesture_timeout_ms;
      reach = int'(cur_cfg.drag_threshold) + int'(cur_cfg.drag_threshold) / 2 + 3;
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(3))
          0: send_ack();
          1: send_touch($urandom, $urandom, $urandom);
          2: begin
            now_ms += $urandom_range(0, 200);
            if ($urandom_range(1))
              send_touch(-int'($urandom_range(1, 2048)), $urandom_range(0, 2047), now_ms);
            else
              send_touch($urandom_range(0, 2047), $urandom_range(h, 2047), now_ms);
          end
          default: send_touch($urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
        endcase
        done_n++;
      end else begin
        now_ms += tmo + $urandom_range(0, 40);
        if ($urandom_range(15) == 0)
          now_ms += $urandom;
        sx = $urandom_range(0, w - 1);
        sy = $urandom_range(0, h - 1);
        send_touch(sx, sy, now_ms);
        len = $urandom_range(1, 6);
        repeat (len) begin
          case ($urandom_range(7))
            0: step = tmo;
            1: step = (tmo == 0) ? 0 : tmo - 1;
            default: step = (tmo == 0) ? 0 : $urandom_range(0, tmo - 1);
          endcase
          now_ms += step;
          ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach, w - 1);
          ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach, h - 1);
          if ($urandom_range(9) == 0)
            send_touch(ex, -1, now_ms);   // lost reading mid-gesture
          else
            send_touch(ex, ey, now_ms);
        end
        if ($urandom_range(9) != 0)
          send_ack();
        done_n += len + 2;
      end
    end
  endtask

  task automatic set_random_config();
    set_config($urandom_range(1, 2048), $urandom_range(1, 2048),
               $urandom_range(0, 300), $urandom_range(0, 64));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    hold_req      = 1'b0;
    src_idle_pct  = 35;
    sink_idle_pct = 64;
    items_sent    = 0;
    acks_sent     = 0;
    settings_used = 0;
    now_ms        = '0;
    cur_cfg.x_limit            = 12'd320;
    cur_cfg.y_limit            = 12'd240;
    cur_cfg.gesture_timeout_ms = 16'd50;
    cur_cfg.drag_threshold     = 12'd10;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    send_ack();                           // nothing pending yet
    send_touch(5, 5, 10);                 // before timeout: start stays at origin
    send_touch(319, 239, 100);            // new gesture at the far corner
    send_touch(320, 0, 105);              // x on the width bound
    send_touch(0, 240, 105);              // y on the height bound
    send_touch(-1, 5, 105);
    send_touch(-2048, 2047, 105);
    send_touch(0, 0, 110);                // long drag back to origin
    send_ack();
    send_ack();                           // cleared: kind none, points kept
    send_touch(100, 100, 200);
    send_touch(106, 108, 210);            // distance exactly the threshold
    send_touch(106, 107, 220);            // just under
    send_touch(150, 120, 269);            // gap one short of timeout
    send_touch(150, 120, 319);            // gap equal to timeout
    send_touch(10, 10, 32'hFFFF_FFF0);
    send_touch(12, 10, 32'h0000_0010);    // timestamp wraps inside a gesture
    send_touch(2047, -1, 32'hFFFF_FFFF);
    send_ack();

    set_config(2048, 2048, 0, 0);         // every sample restarts, all drags
    send_touch(2047, 2047, 5);
    send_touch(0, 0, 5);
    send_ack();

    set_config(1, 1, 65535, 4095);        // single-pixel screen
    send_touch(0, 0, 100);
    send_touch(1, 0, 101);
    send_touch(0, 1, 102);
    send_ack();

    // random phases
    set_config(320, 240, 50, 10);
    run_phase(PHASE_ITEMS);
    set_config(2048, 2048, 0, 0);
    now_ms = 32'hFFFF_F000;
    run_phase(PHASE_ITEMS);

    src_idle_pct  = 64;
    sink_idle_pct = 35;
    set_config(1, 1, 65535, 4095);
    run_phase(PHASE_ITEMS);
    set_random_config();
    run_phase(PHASE_ITEMS);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_config(2048, 2048, 65535, 4095);
    hold_req = 1'b1;                      // long result hold-off; the input stalls behind it
    run_phase(PHASE_ITEMS);
    set_random_config();
    run_phase(PHASE_ITEMS / 2);
    settle();
    set_config(16, 12, 3, 4);
    run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);

    settle();
    $display("covered %0d items (%0d acknowledges) across %0d register settings,",
             items_sent, acks_sent, settings_used + 1);
    $display("with source/sink idling, a long result hold and full drains");
    if (fail_count == 0 && results_due == 0)
      $display("touch_tap_drag_classifier_unit_tb: PASS");
    else
      $display("touch_tap_drag_classifier_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ttd_pkg.sv
rtl/core/ttd_chan_if.sv
rtl/core/ttd_cfg_regs.sv
rtl/core/ttd_state.sv
rtl/core/ttd_classify.sv
rtl/core/touch_tap_drag_classifier_unit.sv
tb/ttd_result_checker.sv
tb/touch_tap_drag_classifier_unit_tb.sv
